// File: sv/ffp_pkg.sv
// ffp_pkg: shared constants, types and helpers for the fixed frame packer
// no dependencies; imported by the planner, the top level and the testbench
package ffp_pkg;

  // frame geometry and separator marker
  localparam logic [9:0]  FRAME_SIZE = 10'd1020;
  localparam logic [31:0] SEP_MARKER = 32'h49524F4E;

  // result kinds
  localparam logic [1:0] KIND_MSG = 2'd0;
  localparam logic [1:0] KIND_PAD = 2'd1;
  localparam logic [1:0] KIND_SEP = 2'd2;

  // emit sequence positions: padding run, eight separator bytes, message byte
  localparam logic [3:0] IDX_PAD      = 4'd0;
  localparam logic [3:0] IDX_SEP0     = 4'd1;
  localparam logic [3:0] IDX_SEP_LAST = 4'd8;
  localparam logic [3:0] IDX_MSG      = 4'd9;

  // what one accepted word turns into
  typedef struct packed {
    logic        pad;
    logic [9:0]  pad_count;
    logic        sep;
    logic [15:0] sum;
    logic [7:0]  data;
  } plan_t;

  // separator byte at a sequence position, most significant byte first
  function automatic logic [7:0] sep_byte(input logic [3:0] idx, input logic [15:0] sum);
    logic [63:0] word;
    logic [2:0]  pos;
    word = {sum, SEP_MARKER, 6'd0, FRAME_SIZE};
    pos  = 3'(idx - IDX_SEP0);
    sep_byte = word[8 * (3'd7 - pos) +: 8];
  endfunction

endpackage

// File: sv/ffp_in_if.sv
// ffp_in_if: valid/ready channel carrying one message word into the packer
// no dependencies
interface ffp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [9:0] message_length;
  logic       first_of_message;

  modport source (output valid, data_byte, message_length, first_of_message, input ready);
  modport sink   (input valid, data_byte, message_length, first_of_message, output ready);
endinterface

// File: sv/ffp_out_if.sv
// ffp_out_if: valid/ready channel carrying one packed output word
// no dependencies
interface ffp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [9:0] pad_count;
  logic       last_of_run;

  modport source (output valid, out_kind, out_byte, pad_count, last_of_run, input ready);
  modport sink   (input valid, out_kind, out_byte, pad_count, last_of_run, output ready);
endinterface

// File: sv/ffp_plan.sv
// ffp_plan: frame check for one input word; decides padding and separator
// and computes the next frame fill and checksum; depends on ffp_pkg
module ffp_plan import ffp_pkg::*; (
  input  logic [7:0]  data_byte,
  input  logic [9:0]  message_length,
  input  logic        first_of_message,
  input  logic [9:0]  fill,
  input  logic [15:0] checksum,
  output plan_t       plan,
  output logic [9:0]  fill_next,
  output logic [15:0] checksum_next
);

  logic [10:0] fit_sum;
  logic        need_pad;
  logic [9:0]  fill_pad;
  logic        need_sep;
  logic [9:0]  fill_base;
  logic [10:0] booked;
  logic [15:0] sum_base;

  // padding when the message overruns a frame that is not yet full
  always_comb begin
    fit_sum  = {1'b0, fill} + {1'b0, message_length};
    need_pad = first_of_message && (fill < FRAME_SIZE) && (fit_sum > {1'b0, FRAME_SIZE});
    fill_pad = need_pad ? FRAME_SIZE : fill;
    need_sep = first_of_message && (fill_pad >= FRAME_SIZE);
  end

  // book the message length, saturating at the frame size
  always_comb begin
    fill_base = need_sep ? 10'd0 : fill_pad;
    booked    = {1'b0, fill_base} + {1'b0, message_length};
    if (!first_of_message) begin
      fill_next = fill;
    end else if (booked > {1'b0, FRAME_SIZE}) begin
      fill_next = FRAME_SIZE;
    end else begin
      fill_next = booked[9:0];
    end
  end

  // checksum restarts after a separator
  always_comb begin
    sum_base      = need_sep ? 16'd0 : checksum;
    checksum_next = sum_base + {8'd0, data_byte};
  end

  always_comb begin
    plan.pad       = need_pad;
    plan.pad_count = FRAME_SIZE - fill;
    plan.sep       = need_sep;
    plan.sum       = checksum;
    plan.data      = data_byte;
  end

endmodule

// File: sv/fixed_frame_packer.sv
// fixed_frame_packer: top level; frame state, emit sequencer and output register
// depends on ffp_pkg, ffp_in_if, ffp_out_if and ffp_plan
//
// Usage:
//   items   : message words in (data_byte, message_length, first_of_message);
//             message_length is looked at only when first_of_message is set.
//   results : packed words out (out_kind, out_byte, pad_count, last_of_run).
//             Kinds are message byte, one zero padding run (pad_count zeros)
//             and separator byte; last_of_run marks the message byte that
//             closes the results of one input word.
// Path: an accepted word is registered in the sequencer stage, and its
//   results then load the output register whenever that register is free
//   or being read.
// Throughput: one word per cycle inside a frame unless the receiver stalls. A
//   first byte that closes a frame holds the sequencer for separator + byte or
//   padding run + separator + byte; it emits one result a cycle while unstalled.
// Reset: synchronous; the frame counts as full and the checksum is zero, so
//   the first message is preceded by a separator. Output valid drops.
// Receiver stall: the output register holds its word; the sequencer and then
//   the input side stop. The next input is taken in the same cycle the last
//   result of the current one moves into the output register.
module fixed_frame_packer import ffp_pkg::*; (
  input logic     clk,
  input logic     rst,
  ffp_in_if.sink  items,
  ffp_out_if.source results
);

  logic [9:0]  fill;
  logic [15:0] checksum;
  logic [9:0]  fill_next;
  logic [15:0] checksum_next;
  plan_t       plan;

  logic        s_valid;
  plan_t       s_plan;
  logic [3:0]  s_idx;
  logic [3:0]  s_idx_next;
  logic [3:0]  start_idx;

  logic        out_load;
  logic        emit;
  logic        emit_last;
  logic        take;

  ffp_plan u_plan (
    .data_byte        (items.data_byte),
    .message_length   (items.message_length),
    .first_of_message (items.first_of_message),
    .fill             (fill),
    .checksum         (checksum),
    .plan             (plan),
    .fill_next        (fill_next),
    .checksum_next    (checksum_next)
  );

  // handshake glue
  always_comb begin
    out_load    = !results.valid || results.ready;
    emit        = s_valid && out_load;
    emit_last   = emit && (s_idx == IDX_MSG);
    items.ready = !s_valid || emit_last;
    take        = items.valid && items.ready;
  end

  // frame state advances when a word is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= FRAME_SIZE;
      checksum <= 16'd0;
    end else if (take) begin
      fill     <= fill_next;
      checksum <= checksum_next;
    end
  end

  // first and following sequence positions
  always_comb begin
    if (plan.pad) begin
      start_idx = IDX_PAD;
    end else if (plan.sep) begin
      start_idx = IDX_SEP0;
    end else begin
      start_idx = IDX_MSG;
    end
    case (s_idx)
      IDX_PAD:      s_idx_next = IDX_SEP0;
      IDX_SEP_LAST: s_idx_next = IDX_MSG;
      default:      s_idx_next = s_idx + 4'd1;
    endcase
  end

  // sequencer stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (take) begin
      s_valid <= 1'b1;
    end else if (emit_last) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_plan <= plan;
      s_idx  <= start_idx;
    end else if (emit) begin
      s_idx  <= s_idx_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (emit) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      case (s_idx)
        IDX_PAD: begin
          results.out_kind    <= KIND_PAD;
          results.out_byte    <= 8'd0;
          results.pad_count   <= s_plan.pad_count;
          results.last_of_run <= 1'b0;
        end
        IDX_MSG: begin
          results.out_kind    <= KIND_MSG;
          results.out_byte    <= s_plan.data;
          results.pad_count   <= 10'd0;
          results.last_of_run <= 1'b1;
        end
        default: begin
          results.out_kind    <= KIND_SEP;
          results.out_byte    <= sep_byte(s_idx, s_plan.sum);
          results.pad_count   <= 10'd0;
          results.last_of_run <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // booked fill never passes the frame size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FRAME_SIZE)
    else $error("frame fill above frame size");

  // a padding run is always followed by the separator
  a_pad_then_sep: assert property (@(posedge clk) disable iff (rst)
    (emit && s_idx == IDX_PAD) |=> (s_valid && s_idx == IDX_SEP0))
    else $error("padding run not followed by separator");

  // no new word while earlier results are still queued in the sequencer
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s_valid && items.ready) |-> emit_last)
    else $error("input taken while sequencer busy");

  // only the message byte closes a run
  a_last_is_msg: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.last_of_run == (results.out_kind == KIND_MSG)))
    else $error("run end on wrong result kind");
`endif

endmodule

// File: dv/tb_fixed_frame_packer.sv
// tb_fixed_frame_packer: self-checking testbench for the fixed frame packer
// depends on ffp_pkg, ffp_in_if, ffp_out_if and fixed_frame_packer
`timescale 1ns / 100ps

module tb_fixed_frame_packer import ffp_pkg::*;;

  localparam int RANDOM_WORDS = 430;
  localparam int STALL_PCT    = 29;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct {
    logic [7:0] data_byte;
    logic [9:0] message_length;
    logic       first_of_message;
    bit         hold_for_drain;
  } msg_word_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic [9:0] pad;
    logic       last;
  } packed_word_t;

  logic clk = 1'b0;
  logic rst;

  ffp_in_if  in_ch();
  ffp_out_if out_ch();

  fixed_frame_packer i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (in_ch),
    .results (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  msg_word_t    pending_words[$];
  packed_word_t expected_words[$];
  msg_word_t    word_on_bus;
  int           frame_fill_level;
  logic [15:0]  frame_sum;
  int           words_sent;
  int           mismatches;
  int           quiet_cycles;

  // stretch of the run where neither side stalls
  function automatic bit no_stall_window(input int sent);
    return sent >= 150 && sent < 260;
  endfunction

  // expected output words for one accepted message word
  function void predict_frame_words(input msg_word_t w);
    packed_word_t r;
    logic [63:0]  sep_bytes;
    if (w.first_of_message) begin
      if (frame_fill_level < int'(FRAME_SIZE) &&
          frame_fill_level + int'(w.message_length) > int'(FRAME_SIZE)) begin
        r = '{KIND_PAD, 8'd0, 10'(int'(FRAME_SIZE) - frame_fill_level), 1'b0};
        expected_words.push_back(r);
        frame_fill_level = int'(FRAME_SIZE);
      end
      if (frame_fill_level >= int'(FRAME_SIZE)) begin
        sep_bytes = {frame_sum, SEP_MARKER, 16'(FRAME_SIZE)};
        for (int i = 0; i < 8; i++) begin
          r = '{KIND_SEP, sep_bytes[63 - 8 * i -: 8], 10'd0, 1'b0};
          expected_words.push_back(r);
        end
        frame_sum = 16'd0;
        frame_fill_level = 0;
      end
      frame_fill_level += int'(w.message_length);
      if (frame_fill_level > int'(FRAME_SIZE)) frame_fill_level = int'(FRAME_SIZE);
    end
    frame_sum = frame_sum + 16'(w.data_byte);
    r = '{KIND_MSG, w.data_byte, 10'd0, 1'b1};
    expected_words.push_back(r);
  endfunction

  task automatic queue_word(input logic [7:0] data, input logic [9:0] len,
                            input logic first, input bit drain);
    msg_word_t w;
    w = '{data, len, first, drain};
    pending_words.push_back(w);
  endtask

  // first word declares len; nbytes words are actually sent
  task automatic queue_message(input logic [9:0] len, input int nbytes, input bit drain);
    queue_word(8'($urandom), len, 1'b1, drain);
    for (int i = 1; i < nbytes; i++)
      queue_word(8'($urandom), 10'($urandom_range(1023)), 1'b0, 1'b0);
  endtask

  // driver: present pending words, predict on accept
  always @(posedge clk) begin
    msg_word_t nxt;
    bit        go;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_frame_words(word_on_bus);
        words_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        go = pending_words.size() != 0 &&
             (no_stall_window(words_sent) || $urandom_range(99) >= STALL_PCT);
        if (go && pending_words[0].hold_for_drain && expected_words.size() != 0)
          go = 1'b0;
        if (go) begin
          nxt = pending_words.pop_front();
          word_on_bus <= nxt;
          in_ch.data_byte        <= nxt.data_byte;
          in_ch.message_length   <= nxt.message_length;
          in_ch.first_of_message <= nxt.first_of_message;
          in_ch.valid            <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each output word with the oldest expectation
  always @(posedge clk) begin
    packed_word_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: kind %0d byte %0h pad %0d last %0b", out_ch.out_kind,
                 out_ch.out_byte, out_ch.pad_count, out_ch.last_of_run);
          mismatches++;
        end else begin
          e = expected_words.pop_front();
          if (out_ch.out_kind !== e.kind) begin
            $error("out_kind: expected %0d, actual %0d", e.kind, out_ch.out_kind);
            mismatches++;
          end
          if (out_ch.out_byte !== e.data) begin
            $error("out_byte: expected %0h, actual %0h", e.data, out_ch.out_byte);
            mismatches++;
          end
          if (out_ch.pad_count !== e.pad) begin
            $error("pad_count: expected %0d, actual %0d", e.pad, out_ch.pad_count);
            mismatches++;
          end
          if (out_ch.last_of_run !== e.last) begin
            $error("last_of_run: expected %0b, actual %0b", e.last, out_ch.last_of_run);
            mismatches++;
          end
        end
      end
      out_ch.ready <= no_stall_window(words_sent) || $urandom_range(99) >= STALL_PCT;
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int  pick;
    bit  drain_done;
    rst                    = 1'b1;
    in_ch.valid            = 1'b0;
    in_ch.data_byte        = 8'd0;
    in_ch.message_length   = 10'd0;
    in_ch.first_of_message = 1'b0;
    out_ch.ready           = 1'b0;
    frame_fill_level       = int'(FRAME_SIZE);
    frame_sum              = 16'd0;
    words_sent             = 0;
    mismatches             = 0;
    quiet_cycles           = 0;
    drain_done             = 1'b0;

    // directed: separator after reset, one-byte message, zero data byte
    queue_word(8'h00, 10'd1, 1'b1, 1'b0);
    // declared length beyond the frame: padding run, then fill saturates
    queue_word(8'hFF, 10'd1023, 1'b1, 1'b0);
    queue_word(8'hAA, 10'd0, 1'b0, 1'b0);
    // zero length on a full frame: separator only
    queue_word(8'hFF, 10'd0, 1'b1, 1'b0);
    // zero length on an empty frame: nothing booked, no separator
    queue_word(8'h01, 10'd0, 1'b1, 1'b0);
    // longer than a frame from an empty frame: full-frame padding run
    queue_word(8'h80, 10'd1021, 1'b1, 1'b0);
    // more bytes than declared
    queue_word(8'h7F, 10'd5, 1'b1, 1'b0);
    for (int i = 0; i < 7; i++) queue_word(8'($urandom), 10'h3FF, 1'b0, 1'b0);
    // fewer bytes than declared, exact fit of the frame
    queue_word(8'h55, 10'd1015, 1'b1, 1'b0);
    // continuation word with no message open
    queue_word(8'hFE, 10'h2AA, 1'b0, 1'b0);
    // full frame again, sent only once all results are back
    queue_word(8'h11, 10'd3, 1'b1, 1'b1);
    queue_word(8'h22, 10'h155, 1'b0, 1'b0);
    queue_word(8'h33, 10'd0, 1'b0, 1'b0);

    // random: mostly well-formed messages, some with long declared lengths
    while (pending_words.size() < RANDOM_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 58) begin
        pick = $urandom_range(1, 12);
        queue_message(10'(pick), pick, pending_words.size() > 300 && !drain_done);
        if (pending_words.size() > 300) drain_done = 1'b1;
      end else if (pick < 80) begin
        queue_message(10'($urandom_range(13, 1023)), $urandom_range(1, 6), 1'b0);
      end else if (pick < 88) begin
        queue_message(10'($urandom_range(1, 8)), $urandom_range(1, 12), 1'b0);
      end else if (pick < 94) begin
        queue_word(8'($urandom), 10'($urandom_range(1023)), 1'b0, 1'b0);
      end else if (pick < 97) begin
        queue_message(10'd0, $urandom_range(1, 3), 1'b0);
      end else begin
        queue_message(10'($urandom_range(1021, 1023)), $urandom_range(1, 3), 1'b0);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
